>>> src/modexp_pkg.sv
package modexp_pkg;

	// Default datapath sizes.
	localparam int MOD_BITS_DEF = 32;
	localparam int EXP_BITS_DEF = 32;

	// Width of the register, input and result fields.
	localparam int FIELD_W = 32;

	// APB register map: register index taken from paddr[2].
	localparam int ADDR_W = 3;
	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_EXPONENT = 1'b1;

	localparam logic [FIELD_W-1:0] MODULUS_RST = 32'd1;
	localparam logic [FIELD_W-1:0] EXPONENT_RST = 32'd0;

endpackage

>>> src/modexp_regs.sv
module modexp_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [modexp_pkg::ADDR_W-1:0]       paddr,
	input  logic [modexp_pkg::FIELD_W-1:0]      pwdata,
	output logic [modexp_pkg::FIELD_W-1:0]      prdata,
	output logic                                pready,
	output logic [modexp_pkg::FIELD_W-1:0]      modulus,
	output logic [modexp_pkg::FIELD_W-1:0]      exponent_value
);

	logic [modexp_pkg::FIELD_W-1:0] modulus_q;
	logic [modexp_pkg::FIELD_W-1:0] exponent_q;
	logic                           wr_en;
	logic                           reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= modexp_pkg::MODULUS_RST;
			exponent_q <= modexp_pkg::EXPONENT_RST;
		end else if (wr_en) begin
			case (reg_sel)
				modexp_pkg::REG_MODULUS: modulus_q <= pwdata;
				modexp_pkg::REG_EXPONENT: exponent_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			modexp_pkg::REG_MODULUS: prdata = modulus_q;
			modexp_pkg::REG_EXPONENT: prdata = exponent_q;
			default: prdata = '0;
		endcase
	end

	assign modulus = modulus_q;
	assign exponent_value = exponent_q;

endmodule

>>> src/modexp_mulmod.sv
module modexp_mulmod #(
	parameter int DW = modexp_pkg::MOD_BITS_DEF,
	parameter int BW = modexp_pkg::MOD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] a,
	input  logic [BW-1:0] b,
	input  logic [DW-1:0] m,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] result
);

	localparam int CW = $clog2(BW + 1);
	localparam logic [CW-1:0] CNT_LOAD = CW'(BW);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	logic [DW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [DW-1:0] m_q;
	logic [DW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW+2:0] t;
	logic [DW+2:0] d1;
	logic [DW+2:0] d2;
	logic [DW-1:0] acc_next;

	// One multiplier bit per cycle, most significant first:
	// acc = (2*acc + bit*a) mod m, where the sum stays below 3m.
	always_comb begin
		t = {2'b00, acc_q, 1'b0} + (b_q[BW-1] ? {3'b000, a_q} : '0);
		d1 = t - {3'b000, m_q};
		d2 = t - {2'b00, m_q, 1'b0};
		if (!d2[DW+2]) begin
			acc_next = d2[DW-1:0];
		end else if (!d1[DW+2]) begin
			acc_next = d1[DW-1:0];
		end else begin
			acc_next = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_LOAD;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_ONE;
				if (cnt_q == CNT_ONE) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q <= {b_q[BW-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign result = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("multiplier finished without running");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == CNT_LOAD)
		else $error("multiplier did not start");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && $past(busy_q) && m_q != '0) |-> acc_q < m_q)
		else $error("partial product not reduced below the modulus");

endmodule

>>> src/modular_exponentiation_core.sv
// Channel  | Signals                                   | Direction
// base     | base_valid, base_stall, base_value        | item in
// power    | power_valid, power_stall, power_result    | item out
// config   | psel, penable, pwrite, paddr, pwdata,     | APB registers
//          | prdata, pready                            |
//
// An item reduces the base, then runs multiplies for the set bits and squares
// for the significant bits of the exponent on the shared bit-serial modular
// multiplier, whose multiplier operand width is BW = max(MOD_BITS, 32).
// A zero modulus finishes without using the multiplier, with a result of zero.
// Reset is asynchronous; registers come up with modulus one and exponent zero.
// A new item is taken while a finished result still waits on power_stall.
module modular_exponentiation_core #(
	parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF,
	parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               base_valid,
	output logic                               base_stall,
	input  logic [modexp_pkg::FIELD_W-1:0]     base_value,
	output logic                               power_valid,
	input  logic                               power_stall,
	output logic [modexp_pkg::FIELD_W-1:0]     power_result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [modexp_pkg::ADDR_W-1:0]      paddr,
	input  logic [modexp_pkg::FIELD_W-1:0]     pwdata,
	output logic [modexp_pkg::FIELD_W-1:0]     prdata,
	output logic                               pready
);

	localparam int FW = modexp_pkg::FIELD_W;
	localparam int BW = (MOD_BITS > FW) ? MOD_BITS : FW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_SQR = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [FW-1:0]       modulus;
	logic [FW-1:0]       exponent_value;
	logic [63:0]         mod_wide;
	logic [63:0]         exp_wide;
	logic [63:0]         base_wide;
	logic [MOD_BITS-1:0] m;
	logic [MOD_BITS-1:0] one_mod;

	logic [2:0]          state_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] sq_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [FW-1:0]       out_q;
	logic                out_valid_q;

	logic                mm_start;
	logic [MOD_BITS-1:0] mm_a;
	logic [BW-1:0]       mm_b;
	logic                mm_busy;
	logic                mm_done;
	logic [MOD_BITS-1:0] mm_result;

	logic                in_take;
	logic                out_free;
	logic [EXP_BITS-1:0] exp_next;
	logic [MOD_BITS-1:0] sq_next;
	logic [MOD_BITS-1:0] acc_next;

	modexp_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.modulus        (modulus),
		.exponent_value (exponent_value)
	);

	assign mod_wide = {32'd0, modulus};
	assign exp_wide = {32'd0, exponent_value};
	assign base_wide = {32'd0, base_value};
	assign m = mod_wide[MOD_BITS-1:0];
	assign one_mod = (m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

	assign base_stall = (state_q != S_IDLE);
	assign in_take = base_valid && !base_stall;
	assign out_free = !out_valid_q || !power_stall;

	// Picks the next multiplier operation: the base reduction when an item is taken;
	// once the base is reduced or a square is finished, multiply when the current
	// exponent bit is set, square otherwise; square after a multiply; stop when no set bits remain.
	always_comb begin
		mm_start = 1'b0;
		mm_a = acc_q;
		mm_b = BW'(sq_q);
		exp_next = exp_q;
		sq_next = sq_q;
		acc_next = acc_q;
		case (state_q)
			S_IDLE: begin
				mm_a = one_mod;
				mm_b = base_wide[BW-1:0];
				mm_start = in_take && (m != '0);
			end
			S_RED, S_SQR: begin
				if (state_q == S_RED) begin
					exp_next = exp_wide[EXP_BITS-1:0];
					acc_next = one_mod;
				end
				sq_next = mm_result;
				if (exp_next[0]) begin
					mm_a = acc_next;
					mm_b = BW'(sq_next);
				end else begin
					mm_a = sq_next;
					mm_b = BW'(sq_next);
				end
				mm_start = mm_done && (exp_next != '0);
			end
			S_MUL: begin
				acc_next = mm_result;
				exp_next = exp_q >> 1;
				mm_a = sq_q;
				mm_b = BW'(sq_q);
				mm_start = mm_done && (exp_next != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !power_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= (m == '0) ? S_DONE : S_RED;
					end
				end
				S_RED, S_SQR: begin
					if (mm_done) begin
						if (exp_next == '0) begin
							state_q <= S_DONE;
						end else if (exp_next[0]) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_SQR;
						end
					end
				end
				S_MUL: begin
					if (mm_done) begin
						state_q <= (exp_next == '0) ? S_DONE : S_SQR;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					acc_q <= '0;
				end
			end
			S_RED, S_SQR: begin
				if (mm_done) begin
					acc_q <= acc_next;
					sq_q <= sq_next;
					// A square is started on an even bit: drop that bit now.
					exp_q <= exp_next[0] ? exp_next : (exp_next >> 1);
				end
			end
			S_MUL: begin
				if (mm_done) begin
					acc_q <= acc_next;
					exp_q <= exp_next;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_q <= FW'(acc_q);
				end
			end
			default: ;
		endcase
	end

	modexp_mulmod #(
		.DW (MOD_BITS),
		.BW (BW)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (m),
		.busy   (mm_busy),
		.done   (mm_done),
		.result (mm_result)
	);

	assign power_valid = out_valid_q;
	assign power_result = out_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_busy)
		else $error("multiplier started while running");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mm_busy)
		else $error("multiplier running outside an item");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> out_valid_q && state_q == S_IDLE)
		else $error("finished item not presented");

endmodule
